/* rtl/ccrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage code run segmenter package
// Shared widths, record codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ccrs_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int POS_WIDTH_DEF   = 32;

   localparam int CODE_W    = 8;
   localparam int NIBBLE_W  = 4;
   localparam int DEPTH_W   = 3;
   localparam int TYPE_W    = 4;
   localparam int CLASS_W   = 3;
   localparam int OUT_POS_W = 32;
   localparam int STAT_W    = 32;

   localparam logic               KIND_SEGMENT = 1'b0;
   localparam logic               KIND_STAT    = 1'b1;
   localparam logic [DEPTH_W-1:0] DEPTH_SINGLE = 3'd1;

   typedef struct packed {
      logic boundary;
      logic fin;
      logic out_free;
   } ccrs_status_type;

   typedef struct packed {
      logic step;
      logic emit_seg;
      logic seg_last;
      logic clear_run;
      logic emit_stat;
      logic stat_last;
   } ccrs_cmd_type;

endpackage

/* rtl/ccrs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage code run segmenter channels
// Valid and ready channels for the position codes and for the result records.
// ----------------------------------------------------------------------------
interface ccrs_req_if
   import ccrs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code;
   logic              last_of_contig;

   modport source (output valid, output code, output last_of_contig, input ready);
   modport sink   (input valid, input code, input last_of_contig, output ready);
endinterface

interface ccrs_rsp_if
   import ccrs_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [OUT_POS_W-1:0] seg_start;
   logic [OUT_POS_W-1:0] seg_end;
   logic [DEPTH_W-1:0]   depth;
   logic [TYPE_W-1:0]    type_index;
   logic                 gap_flag;
   logic [CLASS_W-1:0]   class_index;
   logic [STAT_W-1:0]    class_length;
   logic [STAT_W-1:0]    class_count;
   logic                 last;

   modport source (output valid, output kind, output seg_start, output seg_end,
                   output depth, output type_index, output gap_flag,
                   output class_index, output class_length, output class_count,
                   output last, input ready);
   modport sink   (input valid, input kind, input seg_start, input seg_end,
                   input depth, input type_index, input gap_flag,
                   input class_index, input class_length, input class_count,
                   input last, output ready);
endinterface

/* rtl/ccrs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage code run segmenter datapath
// Holds the open run, the position counter, the per-class statistics and the
// result register, and acts on commands from the controller.
// ----------------------------------------------------------------------------
module ccrs_datapath
   import ccrs_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   parameter int POS_WIDTH   = POS_WIDTH_DEF,
   localparam int CLS_W      = $clog2(NUM_CLASSES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CODE_W-1:0]     req_code,
   input  logic                  req_last_of_contig,
   input  ccrs_cmd_type          cmd,
   input  logic [CLS_W-1:0]      stat_idx,
   output ccrs_status_type       status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [OUT_POS_W-1:0]  rsp_seg_start,
   output logic [OUT_POS_W-1:0]  rsp_seg_end,
   output logic [DEPTH_W-1:0]    rsp_depth,
   output logic [TYPE_W-1:0]     rsp_type_index,
   output logic                  rsp_gap_flag,
   output logic [CLASS_W-1:0]    rsp_class_index,
   output logic [STAT_W-1:0]     rsp_class_length,
   output logic [STAT_W-1:0]     rsp_class_count,
   output logic                  rsp_last
);

   localparam int EXT_W = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;
   localparam int CMP_W = DEPTH_W + 1;

   logic [POS_WIDTH-1:0] position_ff, position_in;
   logic [POS_WIDTH-1:0] run_start_ff, run_start_in;
   logic [NIBBLE_W-1:0]  run_code_ff, run_code_in;
   logic [TYPE_W-1:0]    run_type_ff, run_type_in;
   logic                 run_open_ff, run_open_in;
   logic [STAT_W-1:0]    sums_ff [NUM_CLASSES];
   logic [STAT_W-1:0]    sums_in [NUM_CLASSES];
   logic [STAT_W-1:0]    counts_ff [NUM_CLASSES];
   logic [STAT_W-1:0]    counts_in [NUM_CLASSES];

   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff, out_kind_in;
   logic [OUT_POS_W-1:0] out_start_ff, out_start_in;
   logic [OUT_POS_W-1:0] out_end_ff, out_end_in;
   logic [DEPTH_W-1:0]   out_depth_ff, out_depth_in;
   logic [TYPE_W-1:0]    out_type_ff, out_type_in;
   logic                 out_gap_ff, out_gap_in;
   logic [CLASS_W-1:0]   out_class_ff, out_class_in;
   logic [STAT_W-1:0]    out_length_ff, out_length_in;
   logic [STAT_W-1:0]    out_count_ff, out_count_in;
   logic                 out_last_ff, out_last_in;

   logic [NIBBLE_W-1:0]  code_lo;
   logic [TYPE_W-1:0]    code_hi;
   logic [DEPTH_W-1:0]   run_depth;
   logic                 boundary;
   logic                 out_free;
   logic [POS_WIDTH-1:0] seg_len;
   logic [EXT_W-1:0]     start_ext;
   logic [EXT_W-1:0]     end_ext;
   logic [EXT_W-1:0]     len_ext;
   logic                 counted;
   logic [CLS_W-1:0]     stat_addr;
   logic [STAT_W-1:0]    sum_rd;
   logic [STAT_W-1:0]    count_rd;

   assign code_lo   = req_code[NIBBLE_W-1:0];
   assign code_hi   = req_code[CODE_W-1:NIBBLE_W];
   assign run_depth = run_code_ff[DEPTH_W-1:0];
   assign boundary  = run_open_ff &&
                      ((code_lo != run_code_ff) ||
                       ((run_depth == DEPTH_SINGLE) && (code_hi != run_type_ff)));
   assign out_free  = !out_valid_ff || rsp_ready;

   assign status.boundary = boundary;
   assign status.fin      = req_last_of_contig;
   assign status.out_free = out_free;

   assign seg_len   = position_ff - run_start_ff;
   assign start_ext = EXT_W'(run_start_ff);
   assign end_ext   = EXT_W'(position_ff);
   assign len_ext   = EXT_W'(seg_len);
   assign counted   = {1'b0, run_depth} < CMP_W'(NUM_CLASSES);
   assign stat_addr = cmd.emit_stat ? stat_idx : run_depth[CLS_W-1:0];
   assign sum_rd    = sums_ff[stat_addr];
   assign count_rd  = counts_ff[stat_addr];

   always_comb begin
      position_in  = position_ff;
      run_start_in = run_start_ff;
      run_code_in  = run_code_ff;
      run_type_in  = run_type_ff;
      run_open_in  = run_open_ff;
      if (cmd.step) begin
         if (!run_open_ff || boundary) begin
            run_start_in = position_ff;
            run_code_in  = code_lo;
            run_type_in  = code_hi;
            run_open_in  = 1'b1;
         end
         position_in = position_ff + POS_WIDTH'(1);
      end
      if (cmd.clear_run) begin
         position_in  = '0;
         run_start_in = '0;
         run_code_in  = '0;
         run_type_in  = '0;
         run_open_in  = 1'b0;
      end
   end

   always_comb begin
      sums_in   = sums_ff;
      counts_in = counts_ff;
      if (cmd.emit_stat) begin
         sums_in[stat_addr]   = '0;
         counts_in[stat_addr] = '0;
      end else if (cmd.emit_seg && counted) begin
         sums_in[stat_addr]   = sum_rd + len_ext[OUT_POS_W-1:0];
         counts_in[stat_addr] = count_rd + STAT_W'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_start_in  = out_start_ff;
      out_end_in    = out_end_ff;
      out_depth_in  = out_depth_ff;
      out_type_in   = out_type_ff;
      out_gap_in    = out_gap_ff;
      out_class_in  = out_class_ff;
      out_length_in = out_length_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit_seg) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_SEGMENT;
         out_start_in  = start_ext[OUT_POS_W-1:0];
         out_end_in    = end_ext[OUT_POS_W-1:0];
         out_depth_in  = run_depth;
         out_type_in   = (run_depth == DEPTH_SINGLE) ? run_type_ff : '0;
         out_gap_in    = run_code_ff[DEPTH_W];
         out_class_in  = '0;
         out_length_in = '0;
         out_count_in  = '0;
         out_last_in   = cmd.seg_last;
      end else if (cmd.emit_stat) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_STAT;
         out_start_in  = '0;
         out_end_in    = '0;
         out_depth_in  = '0;
         out_type_in   = '0;
         out_gap_in    = 1'b0;
         out_class_in  = CLASS_W'(stat_idx);
         out_length_in = sum_rd;
         out_count_in  = count_rd;
         out_last_in   = cmd.stat_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         run_start_ff <= '0;
         run_code_ff  <= '0;
         run_type_ff  <= '0;
         run_open_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            sums_ff[i]   <= '0;
            counts_ff[i] <= '0;
         end
      end else begin
         position_ff  <= position_in;
         run_start_ff <= run_start_in;
         run_code_ff  <= run_code_in;
         run_type_ff  <= run_type_in;
         run_open_ff  <= run_open_in;
         out_valid_ff <= out_valid_in;
         sums_ff      <= sums_in;
         counts_ff    <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_start_ff  <= out_start_in;
      out_end_ff    <= out_end_in;
      out_depth_ff  <= out_depth_in;
      out_type_ff   <= out_type_in;
      out_gap_ff    <= out_gap_in;
      out_class_ff  <= out_class_in;
      out_length_ff <= out_length_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_seg_start    = out_start_ff;
   assign rsp_seg_end      = out_end_ff;
   assign rsp_depth        = out_depth_ff;
   assign rsp_type_index   = out_type_ff;
   assign rsp_gap_flag     = out_gap_ff;
   assign rsp_class_index  = out_class_ff;
   assign rsp_class_length = out_length_ff;
   assign rsp_class_count  = out_count_ff;
   assign rsp_last         = out_last_ff;

`ifndef SYNTH
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_seg || cmd.emit_stat) |-> out_free)
      else $error("A record was loaded while the result register was occupied.");

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_run |=> (position_ff == '0) && !run_open_ff)
      else $error("The run state did not restart after the contig closed.");

   a_stat_clears_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_stat |=> (sums_ff[$past(stat_addr)] == '0))
      else $error("A class statistic was not cleared after it was reported.");
`endif

endmodule

/* rtl/ccrs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage code run segmenter controller
// Accepts position codes and sequences the closing record and the class
// statistic records at the end of a contig.
// ----------------------------------------------------------------------------
module ccrs_ctrl
   import ccrs_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   localparam int CLS_W      = $clog2(NUM_CLASSES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ccrs_status_type  status,
   output ccrs_cmd_type     cmd,
   output logic [CLS_W-1:0] stat_idx
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FINAL = 2'd1;
   localparam logic [1:0] ST_STATS = 2'd2;

   localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(NUM_CLASSES - 1);

   logic [1:0]       state_ff, state_in;
   logic [CLS_W-1:0] idx_ff, idx_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;
   assign stat_idx  = idx_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd.step      = 1'b0;
      cmd.emit_seg  = 1'b0;
      cmd.seg_last  = 1'b0;
      cmd.clear_run = 1'b0;
      cmd.emit_stat = 1'b0;
      cmd.stat_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.step     = 1'b1;
               cmd.emit_seg = status.boundary;
               cmd.seg_last = !status.fin;
               if (status.fin) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_seg  = 1'b1;
               cmd.clear_run = 1'b1;
               idx_in        = '0;
               state_in      = ST_STATS;
            end
         end
         ST_STATS: begin
            if (status.out_free) begin
               cmd.emit_stat = 1'b1;
               cmd.stat_last = (idx_ff == LAST_CLASS);
               if (idx_ff == LAST_CLASS) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CLS_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTH
   a_fin_goes_final: assert property (@(posedge clock) disable iff (reset)
      (accept && status.fin) |=> (state_ff == ST_FINAL))
      else $error("The end of a contig did not start the closing sequence.");

   a_one_record_kind: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_seg && cmd.emit_stat))
      else $error("A segment and a statistic record were issued together.");

   a_stats_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_stat && cmd.stat_last) |=> (state_ff == ST_IDLE) && (idx_ff == LAST_CLASS))
      else $error("The statistic sequence did not end after the last class.");
`endif

endmodule

/* rtl/coverage_code_run_segmenter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage code run segmenter
// Splits a stream of per-position coverage codes into segments and reports
// per-class length and count statistics at the end of each contig.
// ----------------------------------------------------------------------------
// One position code is accepted per cycle while the result register is free;
// a code that closes a segment loads one segment record into that register.
// A code marked as the last of its contig is followed by the final segment record
// and one statistic record for each of the NUM_CLASSES classes before the next
// code is accepted, all paced by the single result register, so any stall on the
// result side lengthens that sequence.
// ----------------------------------------------------------------------------
module coverage_code_run_segmenter
   import ccrs_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   ccrs_req_if.sink   req_bus,
   ccrs_rsp_if.source rsp_bus
);

   localparam int CLS_W = $clog2(NUM_CLASSES);

   ccrs_status_type  status;
   ccrs_cmd_type     cmd;
   logic [CLS_W-1:0] stat_idx;

   ccrs_ctrl #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd),
      .stat_idx  (stat_idx)
   );

   ccrs_datapath #(
      .NUM_CLASSES (NUM_CLASSES),
      .POS_WIDTH   (POS_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_code           (req_bus.code),
      .req_last_of_contig (req_bus.last_of_contig),
      .cmd                (cmd),
      .stat_idx           (stat_idx),
      .status             (status),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_kind           (rsp_bus.kind),
      .rsp_seg_start      (rsp_bus.seg_start),
      .rsp_seg_end        (rsp_bus.seg_end),
      .rsp_depth          (rsp_bus.depth),
      .rsp_type_index     (rsp_bus.type_index),
      .rsp_gap_flag       (rsp_bus.gap_flag),
      .rsp_class_index    (rsp_bus.class_index),
      .rsp_class_length   (rsp_bus.class_length),
      .rsp_class_count    (rsp_bus.class_count),
      .rsp_last           (rsp_bus.last)
   );

endmodule

/* sim/tb_coverage_code_run_segmenter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage code run segmenter testbench
// Feeds contigs of position codes through the segmenter under random sender
// bursts and receiver stalls, predicts every segment and class statistic
// record in a local model, and checks each result transaction in order.
// ----------------------------------------------------------------------------
module tb_coverage_code_run_segmenter;
   import ccrs_pkg::*;

   localparam int LIMIT       = 400000;
   localparam int ITEM_TARGET = 410;
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int GAP_BIT     = 3;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                 kind;
      logic [OUT_POS_W-1:0] seg_start;
      logic [OUT_POS_W-1:0] seg_end;
      logic [DEPTH_W-1:0]   depth;
      logic [TYPE_W-1:0]    type_index;
      logic                 gap_flag;
      logic [CLASS_W-1:0]   class_index;
      logic [STAT_W-1:0]    class_length;
      logic [STAT_W-1:0]    class_count;
      logic                 last;
   } seg_record_t;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last_of_contig;
   } pos_code_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccrs_req_if req_bus ();
   ccrs_rsp_if rsp_bus ();

   coverage_code_run_segmenter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pos_code_t   pending_codes[$];
   seg_record_t due_records[$];

   logic [POS_WIDTH_DEF-1:0] cov_position;
   logic [POS_WIDTH_DEF-1:0] cov_run_start;
   logic [NIBBLE_W-1:0]      cov_run_code;
   logic [NIBBLE_W-1:0]      cov_run_type;
   logic                     cov_run_open;
   logic [STAT_W-1:0]        cov_len_sum [NUM_CLASSES_DEF];
   logic [STAT_W-1:0]        cov_run_cnt [NUM_CLASSES_DEF];

   int mismatches   = 0;
   int items_in     = 0;
   int contigs_seen = 0;
   int seg_checked  = 0;
   int stat_checked = 0;
   int cycles       = 0;

   task automatic clear_coverage_state();
      cov_position  = '0;
      cov_run_start = '0;
      cov_run_code  = '0;
      cov_run_type  = '0;
      cov_run_open  = 1'b0;
      for (int q = 0; q < NUM_CLASSES_DEF; q++) begin
         cov_len_sum[q] = '0;
         cov_run_cnt[q] = '0;
      end
   endtask

   task automatic close_segment();
      seg_record_t              rec;
      logic [DEPTH_W-1:0]       d;
      logic [POS_WIDTH_DEF-1:0] len;
      d   = cov_run_code[DEPTH_W-1:0];
      len = cov_position - cov_run_start;
      rec = '0;
      rec.kind       = KIND_SEGMENT;
      rec.seg_start  = cov_run_start[OUT_POS_W-1:0];
      rec.seg_end    = cov_position[OUT_POS_W-1:0];
      rec.depth      = d;
      rec.type_index = (d == DEPTH_SINGLE) ? cov_run_type : '0;
      rec.gap_flag   = cov_run_code[GAP_BIT];
      if (int'(d) < NUM_CLASSES_DEF) begin
         cov_len_sum[d] = cov_len_sum[d] + len[STAT_W-1:0];
         cov_run_cnt[d] = cov_run_cnt[d] + 1;
      end
      due_records.push_back(rec);
   endtask

   task automatic segment_code(input pos_code_t item);
      logic [NIBBLE_W-1:0] lo;
      logic [NIBBLE_W-1:0] hi;
      seg_record_t         rec;
      int                  n;
      lo = item.code[NIBBLE_W-1:0];
      hi = item.code[CODE_W-1:NIBBLE_W];
      n  = 0;
      if (!cov_run_open) begin
         cov_run_start = cov_position;
         cov_run_code  = lo;
         cov_run_type  = hi;
         cov_run_open  = 1'b1;
      end else if (lo != cov_run_code ||
                   (cov_run_code[DEPTH_W-1:0] == DEPTH_SINGLE && hi != cov_run_type)) begin
         close_segment();
         n++;
         cov_run_start = cov_position;
         cov_run_code  = lo;
         cov_run_type  = hi;
      end
      cov_position = cov_position + 1;
      if (item.last_of_contig) begin
         close_segment();
         n++;
         for (int q = 0; q < NUM_CLASSES_DEF; q++) begin
            rec = '0;
            rec.kind         = KIND_STAT;
            rec.class_index  = q[CLASS_W-1:0];
            rec.class_length = cov_len_sum[q];
            rec.class_count  = cov_run_cnt[q];
            due_records.push_back(rec);
            n++;
         end
         contigs_seen++;
         clear_coverage_state();
      end
      if (n > 0) begin
         rec = due_records.pop_back();
         rec.last = 1'b1;
         due_records.push_back(rec);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   int        burst_left = 8;
   int        gap_left   = 0;
   pos_code_t next_code;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_codes.size() > 0) begin
            next_code = pending_codes.pop_front();
            req_bus.valid          <= 1'b1;
            req_bus.code           <= next_code.code;
            req_bus.last_of_contig <= next_code.last_of_contig;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: a rotating stall pattern, re-chosen at random, plus one
   // long hold-off that lets the block fill up and back-pressure the sender.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          rx_cycle      = 0;
   int          hold_left     = 0;
   logic        hold_done     = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (!hold_done && items_in >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (rx_cycle % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  ready_pattern = 16'hFFFF;
               end
               1: begin
                  ready_pattern = 16'($urandom);
               end
               2: begin
                  ready_pattern = 16'($urandom) | 16'($urandom);
               end
               default: begin
                  ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
               end
            endcase
         end
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ready_pattern[0];
         end
      end
   end

   // Prediction on accepted codes, then checking of accepted records.
   pos_code_t   taken_code;
   seg_record_t got_record;
   seg_record_t want_record;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken_code.code           = req_bus.code;
            taken_code.last_of_contig = req_bus.last_of_contig;
            segment_code(taken_code);
            items_in <= items_in + 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_record.kind         = rsp_bus.kind;
            got_record.seg_start    = rsp_bus.seg_start;
            got_record.seg_end      = rsp_bus.seg_end;
            got_record.depth        = rsp_bus.depth;
            got_record.type_index   = rsp_bus.type_index;
            got_record.gap_flag     = rsp_bus.gap_flag;
            got_record.class_index  = rsp_bus.class_index;
            got_record.class_length = rsp_bus.class_length;
            got_record.class_count  = rsp_bus.class_count;
            got_record.last         = rsp_bus.last;
            if (due_records.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected result transaction kind=%0b start=%0h end=%0h",
                           $realtime, got_record.kind, got_record.seg_start,
                           got_record.seg_end);
            end else begin
               want_record = due_records.pop_front();
               if (got_record.kind === KIND_STAT)
                  stat_checked++;
               else
                  seg_checked++;
               if (got_record.kind         !== want_record.kind         ||
                   got_record.seg_start    !== want_record.seg_start    ||
                   got_record.seg_end      !== want_record.seg_end      ||
                   got_record.depth        !== want_record.depth        ||
                   got_record.type_index   !== want_record.type_index   ||
                   got_record.gap_flag     !== want_record.gap_flag     ||
                   got_record.class_index  !== want_record.class_index  ||
                   got_record.class_length !== want_record.class_length ||
                   got_record.class_count  !== want_record.class_count  ||
                   got_record.last         !== want_record.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: record mismatch", $realtime);
                     $display("   expected kind=%0b start=%0h end=%0h depth=%0d type=%0h gap=%0b",
                              want_record.kind, want_record.seg_start, want_record.seg_end,
                              want_record.depth, want_record.type_index,
                              want_record.gap_flag);
                     $display("            class=%0d length=%0h count=%0h last=%0b",
                              want_record.class_index, want_record.class_length,
                              want_record.class_count, want_record.last);
                     $display("   actual   kind=%0b start=%0h end=%0h depth=%0d type=%0h gap=%0b",
                              got_record.kind, got_record.seg_start, got_record.seg_end,
                              got_record.depth, got_record.type_index,
                              got_record.gap_flag);
                     $display("            class=%0d length=%0h count=%0h last=%0b",
                              got_record.class_index, got_record.class_length,
                              got_record.class_count, got_record.last);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Timeout after %0d cycles with %0d records outstanding.",
                  cycles, due_records.size());
         $display("FAILURE");
         $finish;
      end
   end

   int          total_items = 0;

   task automatic add_code(input logic [CODE_W-1:0] code, input logic fin);
      pos_code_t item;
      item.code           = code;
      item.last_of_contig = fin;
      pending_codes.push_back(item);
      total_items++;
   endtask

   initial begin
      int                  contig_len;
      int                  k;
      int                  run_len;
      logic [NIBBLE_W-1:0] lo;
      logic [NIBBLE_W-1:0] hi;

      req_bus.valid          = 1'b0;
      req_bus.code           = '0;
      req_bus.last_of_contig = 1'b0;
      rsp_bus.ready          = 1'b0;
      clear_coverage_state();

      // Directed part: single-position contigs, type changes at depth one and
      // elsewhere, gap flips, extreme codes and a closing change on the last
      // position of a contig.
      add_code(8'h25, 1'b1);
      add_code(8'h01, 1'b0);
      add_code(8'h11, 1'b0);
      add_code(8'h11, 1'b0);
      add_code(8'h02, 1'b0);
      add_code(8'h52, 1'b0);
      add_code(8'hF2, 1'b0);
      add_code(8'h0A, 1'b0);
      add_code(8'h8A, 1'b0);
      add_code(8'h00, 1'b0);
      add_code(8'hFF, 1'b0);
      add_code(8'hF7, 1'b0);
      add_code(8'h07, 1'b0);
      add_code(8'h0F, 1'b0);
      add_code(8'hF9, 1'b0);
      add_code(8'h09, 1'b0);
      add_code(8'h00, 1'b1);
      add_code(8'hFF, 1'b0);
      add_code(8'hFF, 1'b1);
      add_code(8'h13, 1'b1);
      add_code(8'hE1, 1'b0);
      add_code(8'hE1, 1'b1);

      // Random contigs built from runs with occasional noise codes.
      while (total_items < ITEM_TARGET) begin
         contig_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
         k = 0;
         while (k < contig_len) begin
            if ($urandom_range(0, 9) == 0) begin
               add_code(8'($urandom_range(0, 255)), k == contig_len - 1);
               k++;
            end else begin
               lo = {1'($urandom_range(0, 3) == 0), 3'($urandom_range(0, 7))};
               if ($urandom_range(0, 2) == 0)
                  lo[DEPTH_W-1:0] = DEPTH_SINGLE;
               hi      = 4'($urandom_range(0, 15));
               run_len = $urandom_range(1, 8);
               for (int j = 0; j < run_len && k < contig_len; j++) begin
                  if ($urandom_range(0, 5) == 0)
                     hi = 4'($urandom_range(0, 15));
                  add_code({hi, lo}, k == contig_len - 1);
                  k++;
               end
            end
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_codes.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (due_records.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);

      $display("Checked %0d position codes over %0d contigs: %0d segment and %0d statistic records.",
               items_in, contigs_seen, seg_checked, stat_checked);
      $display("Receiver stalled in patterns and once for %0d cycles; %0d mismatches.",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
